@@ src/kts_pkg.sv @@
// Shared types, constants and move tables for the knight tour step unit.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package kts_pkg;

    // Board geometry
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);

    // Field widths
    localparam int COORD_W   = 7;
    localparam int STEP_W    = 13;
    localparam int CRD_W     = COORD_W + 2;

    // Move scan
    localparam int NUM_MOVES = 8;
    localparam int MOVE_W    = $clog2(NUM_MOVES);
    localparam int PROBE_W   = 4;
    localparam int CNT_W     = 4;

    // Config port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [STEP_W-1:0]   STEP_MAX   = '1;
    localparam logic [CNT_W-1:0]    BEST_INIT  = CNT_W'(NUM_MOVES + 1);
    localparam logic [PROBE_W-1:0]  PROBE_CAND = '0;
    localparam logic [PROBE_W-1:0]  PROBE_DRAIN = PROBE_W'(NUM_MOVES + 1);
    localparam logic [MOVE_W-1:0]   MOVE_LAST  = MOVE_W'(NUM_MOVES - 1);
    localparam logic [ROW_W-1:0]    ROW_LAST   = ROW_W'(MAX_ROWS - 1);

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic signed [CRD_W-1:0]  t_crd;
    typedef logic [MAX_COLS-1:0]      t_row_word;

    typedef enum logic [1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_SROW = 2'd2,
        REG_SCOL = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_coord rows;
        t_coord cols;
        t_coord srow;
        t_coord scol;
    } t_cfg;

    typedef struct packed {
        logic               restart_load;
        logic               set_nomove;
        logic               clear_we;
        logic [ROW_W-1:0]   clear_row;
        logic               scan_init;
        logic               probe_issue;
        logic [PROBE_W-1:0] probe_idx;
        logic [MOVE_W-1:0]  cand_k;
        logic               cand_done;
        logic               commit;
        logic               mark_rd;
        logic               mark_we;
        logic               out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ended;
        logic found;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DECIDE,
        ST_COMMIT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESULT
    } t_state;

    // Row offset of knight move k
    function automatic t_crd move_dr(input logic [MOVE_W-1:0] k);
        t_crd d;
        unique case (k)
            3'd0, 3'd1: d = t_crd'(-2);
            3'd2, 3'd3: d = t_crd'(-1);
            3'd4, 3'd5: d = t_crd'(1);
            default:    d = t_crd'(2);
        endcase
        return d;
    endfunction

    // Column offset of knight move k
    function automatic t_crd move_dc(input logic [MOVE_W-1:0] k);
        t_crd d;
        unique case (k)
            3'd0, 3'd6: d = t_crd'(1);
            3'd1, 3'd7: d = t_crd'(-1);
            3'd2, 3'd4: d = t_crd'(2);
            default:    d = t_crd'(-2);
        endcase
        return d;
    endfunction

    // Clamp a board dimension to 1..lim
    function automatic t_coord eff_dim(input t_coord v, input int lim);
        t_coord r;
        if (v == '0) begin
            r = t_coord'(1);
        end else if (int'(v) > lim) begin
            r = t_coord'(lim);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp a one-based coordinate to 1..hi
    function automatic t_coord clamp_pos(input t_coord v, input t_coord hi);
        t_coord r;
        if (v == '0) begin
            r = t_coord'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ src/kts_ifs.sv @@
// Valid/ready channel interfaces for the knight tour step unit.
// Depends on kts_pkg for field widths.
`timescale 1ns / 1ps

interface kts_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface kts_res_if;
    logic                          valid;
    logic                          ready;
    logic [kts_pkg::COORD_W-1:0]   cell_row;
    logic [kts_pkg::COORD_W-1:0]   cell_col;
    logic [kts_pkg::STEP_W-1:0]    step_number;
    logic                          moved;
    logic                          finished;

    modport source (output valid, output cell_row, output cell_col, output step_number,
                    output moved, output finished, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input step_number,
                    input moved, input finished, output ready);
endinterface

@@ src/kts_cfg.sv @@
// APB-style configuration registers: board size and start cell.
// Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kts_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [kts_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [kts_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output kts_pkg::t_cfg                    o_cfg
);
    import kts_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    t_coord   w_rd;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write one register per access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows <= t_coord'(8);
            r_cfg.cols <= t_coord'(8);
            r_cfg.srow <= t_coord'(1);
            r_cfg.scol <= t_coord'(1);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROWS: r_cfg.rows <= pwdata[COORD_W-1:0];
                REG_COLS: r_cfg.cols <= pwdata[COORD_W-1:0];
                REG_SROW: r_cfg.srow <= pwdata[COORD_W-1:0];
                REG_SCOL: r_cfg.scol <= pwdata[COORD_W-1:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_ROWS: w_rd = r_cfg.rows;
            REG_COLS: w_rd = r_cfg.cols;
            REG_SROW: w_rd = r_cfg.srow;
            REG_SCOL: w_rd = r_cfg.scol;
        endcase
    end

    assign prdata = CFG_DATA_W'(w_rd);

endmodule

@@ src/kts_ctrl.sv @@
// Sequencer for the knight tour step unit: clear sweep, move scan, commit.
// Depends on kts_pkg; drives kts_dp through a command struct.
`timescale 1ns / 1ps

module kts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_restart,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  kts_pkg::t_dp_status   i_status,
    output kts_pkg::t_dp_cmd      o_cmd
);
    import kts_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [ROW_W-1:0]    r_row;
    logic [MOVE_W-1:0]   r_k;
    logic [PROBE_W-1:0]  r_p;
    logic                r_out_valid;
    logic                w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_restart) begin
                        n_state = ST_CLEAR;
                    end else if (i_status.ended) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_row == ROW_LAST) n_state = ST_RESULT;
            end
            ST_SCAN: begin
                if (r_p == PROBE_DRAIN && r_k == MOVE_LAST) n_state = ST_DECIDE;
            end
            ST_DECIDE:  n_state = ST_COMMIT;
            ST_COMMIT:  n_state = i_status.found ? ST_MARK_RD : ST_RESULT;
            ST_MARK_RD: n_state = ST_MARK_WR;
            ST_MARK_WR: n_state = ST_RESULT;
            ST_RESULT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    priority if (i_restart) begin
                        o_cmd.restart_load = 1'b1;
                    end else if (i_status.ended) begin
                        o_cmd.set_nomove = 1'b1;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                o_cmd.clear_we  = 1'b1;
                o_cmd.clear_row = r_row;
            end
            ST_SCAN: begin
                if (r_p != PROBE_DRAIN) begin
                    o_cmd.probe_issue = 1'b1;
                    o_cmd.probe_idx   = r_p;
                    o_cmd.cand_k      = r_k;
                end
                // close out the previous candidate while the next one starts
                if (r_p == PROBE_CAND && r_k != '0) o_cmd.cand_done = 1'b1;
            end
            ST_DECIDE:  o_cmd.cand_done = 1'b1;
            ST_COMMIT:  o_cmd.commit    = 1'b1;
            ST_MARK_RD: o_cmd.mark_rd   = 1'b1;
            ST_MARK_WR: o_cmd.mark_we   = 1'b1;
            ST_RESULT:  o_cmd.out_load  = w_out_free;
            default: ;
        endcase
    end

    // Loop counters: clear row, candidate move, probe within candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_k   <= '0;
            r_p   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_row <= '0;
                    r_k   <= '0;
                    r_p   <= '0;
                end
                ST_CLEAR: r_row <= r_row + ROW_W'(1);
                ST_SCAN: begin
                    if (r_p == PROBE_DRAIN) begin
                        r_p <= '0;
                        r_k <= r_k + MOVE_W'(1);
                    end else begin
                        r_p <= r_p + PROBE_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output valid: load wins over drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

@@ src/kts_dp.sv @@
// Datapath: visited-cell memory (one row per word), probe pipeline, best-move
// tracking, tour position and result register. Depends on kts_pkg.
`timescale 1ns / 1ps

module kts_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kts_pkg::t_cfg                 i_cfg,
    input  kts_pkg::t_dp_cmd              i_cmd,
    output kts_pkg::t_dp_status           o_status,
    output logic [kts_pkg::COORD_W-1:0]   o_cell_row,
    output logic [kts_pkg::COORD_W-1:0]   o_cell_col,
    output logic [kts_pkg::STEP_W-1:0]    o_step_number,
    output logic                          o_moved,
    output logic                          o_finished
);
    import kts_pkg::*;

    // Visited memory
    t_row_word          r_mem [MAX_ROWS];
    t_row_word          r_rd_data;
    logic [ROW_W-1:0]   w_raddr;
    logic [ROW_W-1:0]   w_waddr;
    t_row_word          w_wdata;
    logic               w_we;

    // Tour state
    t_coord             r_cur_row;
    t_coord             r_cur_col;
    logic [STEP_W-1:0]  r_step;
    logic               r_ended;
    logic               r_moved;

    // Scan state
    t_crd               r_cand_row;
    t_crd               r_cand_col;
    logic               r_cand_free;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_best_n;
    t_coord             r_best_row;
    t_coord             r_best_col;
    logic               r_found;

    // Probe pipeline stage
    logic               r_pv;
    logic               r_pfirst;
    logic               r_pinb;
    logic [COL_W-1:0]   r_pcol;

    // Output register
    t_coord             r_out_row;
    t_coord             r_out_col;
    logic [STEP_W-1:0]  r_out_step;
    logic               r_out_moved;

    t_coord             w_eff_rows;
    t_coord             w_eff_cols;
    t_crd               w_rows_s;
    t_crd               w_cols_s;
    t_crd               w_cur_row_s;
    t_crd               w_cur_col_s;
    logic [MOVE_W-1:0]  w_j;
    t_crd               w_prow;
    t_crd               w_pcol;
    logic               w_pinb;
    logic [ROW_W-1:0]   w_cur_ridx;
    logic [COL_W-1:0]   w_cur_cidx;
    t_row_word          w_cur_bit;
    logic               w_pfree;

    assign w_eff_rows  = eff_dim(i_cfg.rows, MAX_ROWS);
    assign w_eff_cols  = eff_dim(i_cfg.cols, MAX_COLS);
    assign w_rows_s    = t_crd'({2'b00, w_eff_rows});
    assign w_cols_s    = t_crd'({2'b00, w_eff_cols});
    assign w_cur_row_s = t_crd'({2'b00, r_cur_row});
    assign w_cur_col_s = t_crd'({2'b00, r_cur_col});
    assign w_cur_ridx  = ROW_W'(r_cur_row - t_coord'(1));
    assign w_cur_cidx  = COL_W'(r_cur_col - t_coord'(1));
    assign w_cur_bit   = t_row_word'(1) << w_cur_cidx;

    // Probe cell: the candidate itself, or one onward move from the candidate
    assign w_j = MOVE_W'(i_cmd.probe_idx - PROBE_W'(1));
    always_comb begin
        if (i_cmd.probe_idx == PROBE_CAND) begin
            w_prow = w_cur_row_s + move_dr(i_cmd.cand_k);
            w_pcol = w_cur_col_s + move_dc(i_cmd.cand_k);
        end else begin
            w_prow = r_cand_row + move_dr(w_j);
            w_pcol = r_cand_col + move_dc(w_j);
        end
    end
    assign w_pinb = (w_prow > t_crd'(0)) && (w_prow <= w_rows_s) &&
                    (w_pcol > t_crd'(0)) && (w_pcol <= w_cols_s);

    // Memory address and write data
    always_comb begin
        w_raddr = w_cur_ridx;
        if (i_cmd.probe_issue && w_pinb) begin
            w_raddr = ROW_W'(w_prow - t_crd'(1));
        end
        w_we    = i_cmd.clear_we || i_cmd.mark_we;
        w_waddr = i_cmd.clear_we ? i_cmd.clear_row : w_cur_ridx;
        if (i_cmd.clear_we) begin
            // clearing sweep also plants the start cell
            w_wdata = (i_cmd.clear_row == w_cur_ridx) ? w_cur_bit : '0;
        end else begin
            w_wdata = r_rd_data | w_cur_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        // Read for probes and the mark read; hold the word otherwise
        if (i_cmd.probe_issue || i_cmd.mark_rd) r_rd_data <= r_mem[w_raddr];
    end

    // Track probes into the read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.probe_issue;
        end
        r_pfirst <= (i_cmd.probe_idx == PROBE_CAND);
        r_pinb   <= w_pinb;
        r_pcol   <= COL_W'(w_pcol - t_crd'(1));
    end

    assign w_pfree = r_pinb && !r_rd_data[r_pcol];

    // Candidate evaluation and best-move selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_best_n <= BEST_INIT;
        end else begin
            if (i_cmd.scan_init) begin
                r_found  <= 1'b0;
                r_best_n <= BEST_INIT;
            end else if (i_cmd.cand_done && r_cand_free && (r_cnt < r_best_n)) begin
                r_found    <= 1'b1;
                r_best_n   <= r_cnt;
                r_best_row <= r_cand_row[COORD_W-1:0];
                r_best_col <= r_cand_col[COORD_W-1:0];
            end
        end
        if (i_cmd.probe_issue && i_cmd.probe_idx == PROBE_CAND) begin
            r_cand_row <= w_prow;
            r_cand_col <= w_pcol;
        end
        if (r_pv) begin
            if (r_pfirst) begin
                r_cand_free <= w_pfree;
                r_cnt       <= '0;
            end else if (w_pfree) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Tour position, step count and end flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= t_coord'(1);
            r_cur_col <= t_coord'(1);
            r_step    <= '0;
            r_ended   <= 1'b1;
            r_moved   <= 1'b0;
        end else begin
            if (i_cmd.restart_load) begin
                r_cur_row <= clamp_pos(i_cfg.srow, w_eff_rows);
                r_cur_col <= clamp_pos(i_cfg.scol, w_eff_cols);
                r_step    <= STEP_W'(1);
                r_ended   <= 1'b0;
                r_moved   <= 1'b1;
            end else if (i_cmd.set_nomove) begin
                r_moved <= 1'b0;
            end else if (i_cmd.commit) begin
                if (r_found) begin
                    r_cur_row <= r_best_row;
                    r_cur_col <= r_best_col;
                    r_moved   <= 1'b1;
                end else begin
                    r_ended <= 1'b1;
                    r_moved <= 1'b0;
                end
            end else if (i_cmd.mark_we) begin
                if (r_step != STEP_MAX) r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row   <= r_cur_row;
            r_out_col   <= r_cur_col;
            r_out_step  <= r_step;
            r_out_moved <= r_moved;
        end
    end

    assign o_cell_row     = r_out_row;
    assign o_cell_col     = r_out_col;
    assign o_step_number  = r_out_step;
    assign o_moved        = r_out_moved;
    assign o_finished     = !r_out_moved;

    assign o_status.ended = r_ended;
    assign o_status.found = r_found;

endmodule

@@ src/knight_tour_step_unit.sv @@
// Knight tour step unit (Warnsdorff rule): top level.
// Depends on kts_pkg, kts_ifs, kts_cfg, kts_ctrl, kts_dp.
//
// Usage:
//   i_cmd carries one item per transaction: restart=1 clears the board and
//   places the knight on the configured start cell (step 1); restart=0 makes
//   the next move. Every item gives exactly one transaction on o_res with the
//   visited cell, its step number and moved/finished flags.
//   Registers (APB, byte addresses 0/4/8/12): board rows, board columns,
//   start row, start column. Write them only while no item is in flight.
// Sequence per item (one item at a time, i_cmd.ready high only when idle):
//   restart: a clearing sweep over all 64 rows of the visited memory.
//   advance: 8 candidates in turn through the single read port, each with one
//            candidate probe, eight onward probes and one drain, then decide,
//            commit and, if a move is found, a read-modify-write of the new cell.
//   advance after the tour ended (or before any restart): straight to the result.
// Reset: the knight sits at 1,1 with step 0 and the tour counts as ended; the
//   visited memory is not cleared until the first restart.
// Stall: the result sits in an output register; a new item is accepted while
//   it waits, and that item's own result is held until o_res is drained.
`timescale 1ns / 1ps

module knight_tour_step_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kts_cmd_if.sink                          i_cmd,
    kts_res_if.source                        o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kts_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [kts_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [kts_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import kts_pkg::*;

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration registers
    kts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    kts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_restart   (i_cmd.restart),
        .o_in_ready  (i_cmd.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath
    kts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_cell_row    (o_res.cell_row),
        .o_cell_col    (o_res.cell_col),
        .o_step_number (o_res.step_number),
        .o_moved       (o_res.moved),
        .o_finished    (o_res.finished)
    );

    // A visited cell always carries a nonzero step number
    a_moved_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.moved |-> o_res.step_number != '0)
        else $error("moved result with step number zero");

    // Reported cell always lies within the largest board
    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.cell_row != '0) && (o_res.cell_col != '0) &&
                        (o_res.cell_row <= t_coord'(MAX_ROWS)) &&
                        (o_res.cell_col <= t_coord'(MAX_COLS)))
        else $error("result cell outside board range");

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("input accepted while an item is in flight");

    // A restart always reopens the tour
    a_restart_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.restart_load |=> w_status.ended == 1'b0)
        else $error("restart did not reopen the tour");

endmodule
